// ===== hw/rtl/sbmc_pkg.sv =====
`timescale 1ns / 1ps
package sbmc_pkg;
  localparam int WaitCountBits = 20;
  localparam logic [7:0] CmdMeasT  = 8'h03;
  localparam logic [7:0] CmdMeasH  = 8'h05;
  localparam logic [7:0] CmdSreset = 8'h1e;
  localparam logic [3:0] ResetClocks = 4'd9;
  localparam logic [1:0] OpNone   = 2'd0;
  localparam logic [1:0] OpSreset = 2'd3;
  localparam logic [1:0] KindTemp  = 2'd0;
  localparam logic [1:0] KindHumi  = 2'd1;
  localparam logic [1:0] KindReset = 2'd2;
  localparam logic [0:0] RegGap  = 1'b0;
  localparam logic [0:0] RegWait = 1'b1;
endpackage

// ===== hw/rtl/sensor_bus_measure_ctrl_top.sv =====
`timescale 1ns / 1ps
// two-wire sensor bus master, one transaction per bus tick. each accepted input
// transaction advances the bus waveform by one phase and yields exactly one output
// transaction carrying the line levels and status. the result is registered and
// then presented. the tick that completes a measurement first runs the conversion
// through add/multiply steps under a small sequencer (mul1, mul2 for humidity only,
// sum, div, done). the block does not accept while a result is pending or a
// conversion runs, so output stall holds off new input transactions.
module sensor_bus_measure_ctrl_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic        in_data_line,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_clock_level,
  output logic        out_data_drive,
  output logic        out_data_level,
  output logic        out_busy_res,
  output logic        out_result_valid,
  output logic [1:0]  out_result_kind,
  output logic signed [10:0] out_converted_value,
  output logic [15:0] out_raw_reading,
  output logic [7:0]  out_check_byte,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sbmc_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE_HI, PH_IDLE_LO, PH_CR_PRE, PH_CR_HI, PH_CR_LO,
    PH_ST0, PH_ST1, PH_ST2, PH_ST3, PH_ST4, PH_ST5, PH_ST6,
    PH_GAP, PH_WR_A, PH_WR_B, PH_WR_C, PH_WACK_A, PH_WACK_B, PH_WACK_C,
    PH_RWAIT, PH_DWAIT, PH_RD_A, PH_RD_B, PH_RACK_A, PH_RACK_B
  } phase_t;

  typedef enum logic [2:0] {
    SQ_IDLE, SQ_MUL1, SQ_MUL2, SQ_SUM, SQ_DIV, SQ_DONE
  } seq_t;

  // configuration registers
  logic [15:0] gap_r;
  logic [19:0] rwait_r;
  logic        cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    case (paddr[2])
      RegGap:  prdata = {16'd0, gap_r};
      RegWait: prdata = {12'd0, rwait_r};
      default: prdata = '0;
    endcase
  end

  // bus state
  phase_t phase_r, phase_nxt;
  logic [3:0] bit_r, bit_nxt;
  logic [1:0] byte_r, byte_nxt;
  logic [7:0] sh_r, sh_nxt;
  logic [15:0] raw_r, raw_nxt;
  logic [WaitCountBits-1:0] wc_r, wc_nxt;
  logic [1:0] kind_r, kind_nxt;

  // output register
  logic ov_r;
  logic o_clk_r, o_drv_r, o_lvl_r, o_busy_r, o_rv_r;
  logic [1:0] o_kind_r;
  logic signed [10:0] o_conv_r;
  logic [15:0] o_raw_r;
  logic [7:0] o_chk_r;

  // conversion sequencer and its accumulator and product registers
  seq_t sq_r;
  logic signed [47:0] acc_r;
  logic signed [47:0] prod_r;

  logic take;
  assign in_stall = ov_r || (sq_r != SQ_IDLE);
  assign take = in_valid && !in_stall;

  // bus step, combinational
  logic c_clk, c_drv, c_lvl, c_busy, c_fin_meas, c_fin_reset;
  logic [7:0] cmd;
  logic [WaitCountBits-1:0] wmax;
  logic [WaitCountBits:0] wc_inc;
  logic wdone_gap, wdone_rst;
  logic [2:0] wb_idx_a, wb_idx_b;
  phase_t ph;
  logic [1:0] kind_c;

  localparam logic [6:0] StClk = 7'b0110110; // bit k = tick k
  localparam logic [6:0] StDat = 7'b1100011;

  assign wmax = '1;
  assign wc_inc = {1'b0, wc_r} + 1'b1;
  always_comb begin
    logic [31:0] lg, lr;
    lg = 32'(gap_r);
    lr = 32'(rwait_r);
    if (lg > 32'(wmax)) lg = 32'(wmax);
    if (lr > 32'(wmax)) lr = 32'(wmax);
    wdone_gap = 32'(wc_inc) >= lg;
    wdone_rst = 32'(wc_inc) >= lr;
  end

  always_comb begin
    logic [2:0] k;
    ph = phase_r; bit_nxt = bit_r; byte_nxt = byte_r; sh_nxt = sh_r;
    wc_nxt = wc_r; kind_c = kind_r; raw_nxt = raw_r;
    c_clk = 1'b0; c_drv = 1'b0; c_lvl = 1'b1; c_busy = 1'b1;
    c_fin_meas = 1'b0; c_fin_reset = 1'b0;
    if ((phase_r == PH_IDLE_HI || phase_r == PH_IDLE_LO) && in_op != OpNone) begin
      kind_c = in_op - 2'd1;
      bit_nxt = '0; byte_nxt = '0; sh_nxt = '0; wc_nxt = '0;
      ph = (in_op == OpSreset) ? PH_CR_PRE : PH_ST0;
    end
    case (kind_c)
      2'd0:    cmd = CmdMeasT;
      2'd1:    cmd = CmdMeasH;
      default: cmd = CmdSreset;
    endcase
    wb_idx_a = 3'(4'd8 - {1'b0, bit_nxt[2:0]});
    wb_idx_b = 3'(4'd7 - {1'b0, bit_nxt[2:0]});
    phase_nxt = ph;
    k = '0;
    case (ph)
      PH_CR_PRE: phase_nxt = PH_CR_HI;
      PH_CR_HI: begin c_clk = 1'b1; phase_nxt = PH_CR_LO; end
      PH_CR_LO: begin
        if (bit_nxt >= ResetClocks - 4'd1) begin
          bit_nxt = '0; phase_nxt = PH_ST0;
        end else begin
          bit_nxt = bit_nxt + 4'd1; phase_nxt = PH_CR_HI;
        end
      end
      PH_ST0, PH_ST1, PH_ST2, PH_ST3, PH_ST4, PH_ST5, PH_ST6: begin
        k = 3'(ph - PH_ST0);
        c_clk = StClk[k]; c_drv = 1'b1; c_lvl = StDat[k];
        if (ph == PH_ST6) begin
          bit_nxt = '0; wc_nxt = '0;
          phase_nxt = (kind_c >= 2'd2) ? PH_WR_A : PH_GAP;
        end else begin
          phase_nxt = phase_t'(ph + 5'd1);
        end
      end
      PH_GAP: begin
        c_drv = 1'b1;
        if (wdone_gap) begin bit_nxt = '0; phase_nxt = PH_WR_A; end
        else wc_nxt = wc_inc[WaitCountBits-1:0];
      end
      PH_WR_A: begin
        c_drv = 1'b1;
        c_lvl = (bit_nxt == 4'd0) ? 1'b1 : cmd[wb_idx_a];
        phase_nxt = PH_WR_B;
      end
      PH_WR_B: begin c_drv = 1'b1; c_lvl = cmd[wb_idx_b]; phase_nxt = PH_WR_C; end
      PH_WR_C: begin
        c_clk = 1'b1; c_drv = 1'b1; c_lvl = cmd[wb_idx_b];
        if (bit_nxt >= 4'd7) begin bit_nxt = '0; phase_nxt = PH_WACK_A; end
        else begin bit_nxt = bit_nxt + 4'd1; phase_nxt = PH_WR_A; end
      end
      PH_WACK_A: phase_nxt = PH_WACK_B;
      PH_WACK_B: begin c_clk = 1'b1; phase_nxt = PH_WACK_C; end
      PH_WACK_C: begin
        wc_nxt = '0;
        phase_nxt = (kind_c >= 2'd2) ? PH_RWAIT : PH_DWAIT;
      end
      PH_RWAIT: begin
        if (wdone_rst) begin c_fin_reset = 1'b1; phase_nxt = PH_IDLE_LO; end
        else wc_nxt = wc_inc[WaitCountBits-1:0];
      end
      PH_DWAIT: begin
        if (!in_data_line) begin
          bit_nxt = '0; byte_nxt = '0; sh_nxt = '0; phase_nxt = PH_RD_A;
        end
      end
      PH_RD_A: phase_nxt = PH_RD_B;
      PH_RD_B: begin
        c_clk = 1'b1;
        sh_nxt = {sh_nxt[6:0], in_data_line};
        if (bit_nxt >= 4'd7) begin bit_nxt = '0; phase_nxt = PH_RACK_A; end
        else begin bit_nxt = bit_nxt + 4'd1; phase_nxt = PH_RD_A; end
      end
      PH_RACK_A, PH_RACK_B: begin
        if (byte_nxt < 2'd2) begin c_drv = 1'b1; c_lvl = 1'b0; end
        if (ph == PH_RACK_A) phase_nxt = PH_RACK_B;
        else begin
          c_clk = 1'b1;
          if (byte_nxt == 2'd0) begin
            raw_nxt = {sh_nxt, 8'd0}; byte_nxt = 2'd1; sh_nxt = '0;
            bit_nxt = '0; phase_nxt = PH_RD_A;
          end else if (byte_nxt == 2'd1) begin
            raw_nxt = raw_nxt | {8'd0, sh_nxt}; byte_nxt = 2'd2; sh_nxt = '0;
            bit_nxt = '0; phase_nxt = PH_RD_A;
          end else begin
            c_fin_meas = 1'b1; phase_nxt = PH_IDLE_LO;
          end
        end
      end
      PH_IDLE_HI: begin c_clk = 1'b1; c_drv = 1'b1; c_busy = 1'b0; end
      default: begin phase_nxt = PH_IDLE_LO; c_busy = 1'b0; end
    endcase
    kind_nxt = kind_c;
  end

  // conversion: temp = trunc((raw-3966)/100)
  // humi = trunc((405000*raw - 28*raw^2 - 4e7)/1e7), floor 0
  // division by reciprocal multiplication: temp magnitude * 83887 >> 23,
  // humi numerator >> 7 then * 7036875 >> 39 (1e7 = 2^7 * 78125)
  logic humi_r;
  logic [16:0] tmag;
  logic [10:0] q_c;
  assign tmag = acc_r[47] ? 17'(-acc_r) : acc_r[16:0];
  assign q_c = humi_r ? {2'b00, prod_r[47:39]} : prod_r[33:23];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= 16'd1000; rwait_r <= 20'd105100;
      phase_r <= PH_IDLE_HI; bit_r <= '0; byte_r <= '0; sh_r <= '0;
      raw_r <= '0; wc_r <= '0; kind_r <= '0;
      ov_r <= 1'b0; sq_r <= SQ_IDLE;
    end else begin
      if (cfg_wr) begin
        case (paddr[2])
          RegGap:  gap_r <= pwdata[15:0];
          RegWait: rwait_r <= pwdata[19:0];
          default: ;
        endcase
      end
      if (ov_r && !out_stall) ov_r <= 1'b0;
      if (take) begin
        phase_r <= phase_nxt; bit_r <= bit_nxt; byte_r <= byte_nxt; sh_r <= sh_nxt;
        raw_r <= raw_nxt; wc_r <= wc_nxt; kind_r <= kind_nxt;
        o_clk_r <= c_clk; o_drv_r <= c_drv; o_lvl_r <= c_lvl; o_busy_r <= c_busy;
        o_rv_r <= c_fin_meas || c_fin_reset;
        o_kind_r <= c_fin_reset ? KindReset :
                    (c_fin_meas ? ((kind_nxt == KindHumi) ? KindHumi : KindTemp) : 2'd0);
        o_conv_r <= '0;
        o_raw_r <= c_fin_meas ? raw_nxt : 16'd0;
        o_chk_r <= c_fin_meas ? sh_nxt : 8'd0;
        if (c_fin_meas) begin
          humi_r <= (kind_nxt == KindHumi);
          sq_r <= SQ_MUL1;
        end else begin
          ov_r <= 1'b1;
        end
      end
      case (sq_r)
        SQ_IDLE: ;
        SQ_MUL1: begin // raw*raw
          prod_r <= 48'(signed'({1'b0, o_raw_r}) * signed'({1'b0, o_raw_r}));
          sq_r <= humi_r ? SQ_MUL2 : SQ_SUM;
        end
        SQ_MUL2: begin // 405000*raw - 28*raw^2
          acc_r <= 48'(signed'({1'b0, o_raw_r}) * 48'sd405000) - prod_r * 48'sd28;
          sq_r <= SQ_SUM;
        end
        SQ_SUM: begin
          if (humi_r) acc_r <= acc_r - 48'sd40000000;
          else acc_r <= 48'(signed'({1'b0, o_raw_r})) - 48'sd3966;
          sq_r <= SQ_DIV;
        end
        SQ_DIV: begin
          if (humi_r) begin
            // humidity below zero saturates at zero
            if (acc_r > 0) prod_r <= signed'(48'(acc_r[30:7] * 24'd7036875));
            else prod_r <= '0;
          end else begin
            prod_r <= signed'(48'(tmag * 17'd83887));
            if (acc_r < 0) o_conv_r <= 11'sd1;
          end
          sq_r <= SQ_DONE;
        end
        SQ_DONE: begin
          // o_conv_r flags a negated numerator
          o_conv_r <= (o_conv_r != 11'sd0) ? -signed'(q_c) : signed'(q_c);
          ov_r <= 1'b1;
          sq_r <= SQ_IDLE;
        end
        default: sq_r <= SQ_IDLE;
      endcase
    end
  end

  assign out_valid = ov_r;
  assign out_clock_level = o_clk_r;
  assign out_data_drive = o_drv_r;
  assign out_data_level = o_lvl_r;
  assign out_busy_res = o_busy_r;
  assign out_result_valid = o_rv_r;
  assign out_result_kind = o_kind_r;
  assign out_converted_value = o_conv_r;
  assign out_raw_reading = o_raw_r;
  assign out_check_byte = o_chk_r;
endmodule

// ===== hw/rtl/sbmc_checker.sv =====
`timescale 1ns / 1ps
module sbmc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_result_valid,
  input logic [1:0] out_result_kind,
  input logic [15:0] out_raw_reading
);
  import sbmc_pkg::*;
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_raw_reading)) else $error("hold");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("overlap");
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result_valid |-> out_result_kind == KindTemp) else $error("kind");
  a_rst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KindReset |-> out_raw_reading == 16'd0)
    else $error("reset raw");
endmodule

bind sensor_bus_measure_ctrl_top sbmc_checker u_chk (.*);
